[sv/ifd_pkg.sv]
// shared types, codes and constants of the ipv4 forwarding decision block
package ifd_pkg;

  localparam int DEF_ROUTE_ENTRIES = 16;
  localparam int DEF_LOCAL_PORTS   = 4;

  localparam int ADDR_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int LEN_W    = 16;
  localparam int MAXLEN_W = 14;
  localparam int COUNT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_IP_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME    = 3'd5;

  localparam logic [COUNT_W-1:0]  RESET_IFACE_COUNT = 3'd1;
  localparam logic [MAXLEN_W-1:0] RESET_MAX_FRAME   = 14'd1500;

  localparam logic [LEN_W-1:0] MIN_ETH_LEN  = 16'd14;
  localparam logic [LEN_W-1:0] MIN_IP_LEN   = 16'd34;
  localparam logic [LEN_W-1:0] MIN_ICMP_LEN = 16'd38;

  localparam logic [7:0] PROTO_ICMP         = 8'd1;
  localparam logic [7:0] ICMP_ECHO_REQUEST  = 8'd8;
  localparam logic [7:0] ICMP_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] ICMP_UNREACH       = 8'd3;
  localparam logic [7:0] ICMP_CODE_NET      = 8'd0;
  localparam logic [7:0] ICMP_CODE_PORT     = 8'd3;
  localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef enum logic [2:0] {
    V_DROP          = 3'd0,
    V_ECHO          = 3'd1,
    V_PORT_UNREACH  = 3'd2,
    V_TIME_EXCEEDED = 3'd3,
    V_NET_UNREACH   = 3'd4,
    V_FORWARD       = 3'd5,
    V_NOT_IPV4      = 3'd6
  } verdict_t;

  // lookup wavefront handed from cell to cell
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic              found;
    logic [ADDR_W-1:0] best_mask;
    logic [ADDR_W-1:0] hop;
  } wave_t;

  // decision of the header checks ahead of the route lookup
  typedef struct packed {
    logic       need_lookup;
    verdict_t   verdict;
    logic [1:0] port;
    logic [7:0] reply_type;
    logic [7:0] reply_code;
  } pre_t;

endpackage

[sv/ipv4_forwarding_decision.sv]
// top level: ipv4 forwarding decision with a chain of route table cells
// a route load leaves busy low, so the next command may follow at once
// a packet decided by its header gives done in the cycle after start
// a packet that needs a route lookup gives done once the wavefront has crossed every cell,
// one cell per cycle; busy is high meanwhile, so the block takes no new command until
// that lookup has given done. synchronous reset clears all route entries
// and sets the registers to their reset values; the result ports cannot be stalled
module ipv4_forwarding_decision import ifd_pkg::*; #(
  parameter int ROUTE_ENTRIES = DEF_ROUTE_ENTRIES,
  parameter int LOCAL_PORTS   = DEF_LOCAL_PORTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op,
  input  logic [SLOT_W-1:0]     route_slot,
  input  logic [ADDR_W-1:0]     route_prefix,
  input  logic [ADDR_W-1:0]     route_mask,
  input  logic [ADDR_W-1:0]     route_gateway,
  input  logic [LEN_W-1:0]      frame_length,
  input  logic [1:0]            arrival_port,
  input  logic [2:0]            header_checks,
  input  logic [ADDR_W-1:0]     dest_ip,
  input  logic [7:0]            ttl_in,
  input  logic [7:0]            protocol,
  input  logic [15:0]           icmp_type_code,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [2:0]            verdict,
  output logic [ADDR_W-1:0]     next_hop_ip,
  output logic [1:0]            out_port,
  output logic [7:0]            new_ttl,
  output logic [7:0]            icmp_type_out,
  output logic [7:0]            icmp_code_out
);

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   iface_ip [LOCAL_PORTS];
  logic [COUNT_W-1:0]  iface_count;
  logic [MAXLEN_W-1:0] max_frame_length;
  pre_t                pre;
  logic                accept;
  logic                launch;
  logic [1:0]          port_ctx;
  logic [7:0]          ttl_ctx;
  logic                chain_valid [ROUTE_ENTRIES+1];
  wave_t               chain_wave  [ROUTE_ENTRIES+1];
  wave_t               tail;

  assign busy   = (state == S_WALK);
  assign accept = start && !busy;
  assign launch = accept && (op == OP_CLASSIFY) && pre.need_lookup;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LOCAL_PORTS; k++) begin
        iface_ip[k] <= '0;
      end
      iface_count      <= RESET_IFACE_COUNT;
      max_frame_length <= RESET_MAX_FRAME;
    end else if (cfg_write) begin
      for (int k = 0; k < LOCAL_PORTS; k++) begin
        if (cfg_index == REG_IFACE_IP_0 + CFG_IDX_W'(k)) begin
          iface_ip[k] <= cfg_data;
        end
      end
      if (cfg_index == REG_IFACE_COUNT) begin
        iface_count <= cfg_data[COUNT_W-1:0];
      end
      if (cfg_index == REG_MAX_FRAME) begin
        max_frame_length <= cfg_data[MAXLEN_W-1:0];
      end
    end
  end

  ifd_classify #(
    .LOCAL_PORTS(LOCAL_PORTS)
  ) u_classify (
    .frame_length    (frame_length),
    .arrival_port    (arrival_port),
    .header_checks   (header_checks),
    .dest_ip         (dest_ip),
    .ttl_in          (ttl_in),
    .protocol        (protocol),
    .icmp_type_code  (icmp_type_code),
    .iface_ip        (iface_ip),
    .iface_count     (iface_count),
    .max_frame_length(max_frame_length),
    .pre             (pre)
  );

  assign chain_valid[0] = launch;
  assign chain_wave[0]  = '{dest: dest_ip, found: 1'b0, best_mask: '0, hop: '0};

  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
    logic wr_en;
    assign wr_en = accept && (op == OP_LOAD) && (int'(route_slot) == i);
    ifd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en),
      .wr_prefix (route_prefix),
      .wr_mask   (route_mask),
      .wr_gateway(route_gateway),
      .in_valid  (chain_valid[i]),
      .in_wave   (chain_wave[i]),
      .out_valid (chain_valid[i+1]),
      .out_wave  (chain_wave[i+1])
    );
  end

  assign tail = chain_wave[ROUTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (op == OP_CLASSIFY)) begin
            port_ctx <= arrival_port;
            ttl_ctx  <= ttl_in;
            if (pre.need_lookup) begin
              state <= S_WALK;
            end else begin
              done          <= 1'b1;
              verdict       <= pre.verdict;
              next_hop_ip   <= '0;
              out_port      <= pre.port;
              new_ttl       <= 8'd0;
              icmp_type_out <= pre.reply_type;
              icmp_code_out <= pre.reply_code;
            end
          end
        end
        S_WALK: begin
          if (chain_valid[ROUTE_ENTRIES]) begin
            state    <= S_IDLE;
            done     <= 1'b1;
            out_port <= port_ctx;
            if (tail.found) begin
              verdict       <= V_FORWARD;
              // a zero gateway means the destination is directly attached
              next_hop_ip   <= (tail.hop == '0) ? tail.dest : tail.hop;
              new_ttl       <= ttl_ctx - 8'd1;
              icmp_type_out <= 8'd0;
              icmp_code_out <= 8'd0;
            end else begin
              verdict       <= V_NET_UNREACH;
              next_hop_ip   <= '0;
              new_ttl       <= 8'd0;
              icmp_type_out <= ICMP_UNREACH;
              icmp_code_out <= ICMP_CODE_NET;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/ifd_cell.sv]
// one route table cell: holds an entry and updates the passing lookup wavefront
module ifd_cell import ifd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_prefix,
  input  logic [ADDR_W-1:0] wr_mask,
  input  logic [ADDR_W-1:0] wr_gateway,
  input  logic              in_valid,
  input  wave_t             in_wave,
  output logic              out_valid,
  output wave_t             out_wave
);

  logic              entry_valid;
  logic [ADDR_W-1:0] net;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] gateway;
  logic              hit;
  wave_t             wave_next;

  // net is stored already masked
  assign hit = entry_valid && ((in_wave.dest & mask) == net) &&
               (!in_wave.found || (mask > in_wave.best_mask));

  always_comb begin
    wave_next = in_wave;
    if (hit) begin
      wave_next.found     = 1'b1;
      wave_next.best_mask = mask;
      wave_next.hop       = gateway;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (wr_en) begin
        entry_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_wave <= wave_next;
    if (wr_en) begin
      net     <= wr_prefix & wr_mask;
      mask    <= wr_mask;
      gateway <= wr_gateway;
    end
  end

endmodule

[sv/ifd_classify.sv]
// header checks and local interface match ahead of the route lookup
module ifd_classify import ifd_pkg::*; #(
  parameter int LOCAL_PORTS = DEF_LOCAL_PORTS
) (
  input  logic [LEN_W-1:0]    frame_length,
  input  logic [1:0]          arrival_port,
  input  logic [2:0]          header_checks,
  input  logic [ADDR_W-1:0]   dest_ip,
  input  logic [7:0]          ttl_in,
  input  logic [7:0]          protocol,
  input  logic [15:0]         icmp_type_code,
  input  logic [ADDR_W-1:0]   iface_ip [LOCAL_PORTS],
  input  logic [COUNT_W-1:0]  iface_count,
  input  logic [MAXLEN_W-1:0] max_frame_length,
  output pre_t                pre
);

  logic       local_hit;
  logic [1:0] local_port;

  // lowest matching interface wins, so scan downward
  always_comb begin
    local_hit  = 1'b0;
    local_port = 2'd0;
    for (int k = LOCAL_PORTS - 1; k >= 0; k--) begin
      if ((int'(iface_count) > k) && (iface_ip[k] == dest_ip)) begin
        local_hit  = 1'b1;
        local_port = 2'(k);
      end
    end
  end

  always_comb begin
    pre.need_lookup = 1'b0;
    pre.verdict     = V_DROP;
    pre.port        = arrival_port;
    pre.reply_type  = 8'd0;
    pre.reply_code  = 8'd0;
    if ((frame_length < MIN_ETH_LEN) ||
        (frame_length > {{(LEN_W-MAXLEN_W){1'b0}}, max_frame_length})) begin
      pre.verdict = V_DROP;
    end else if (!header_checks[0]) begin
      pre.verdict = V_NOT_IPV4;
    end else if ((frame_length < MIN_IP_LEN) || !header_checks[1]) begin
      pre.verdict = V_DROP;
    end else if (local_hit) begin
      if (protocol == PROTO_ICMP) begin
        if ((frame_length >= MIN_ICMP_LEN) &&
            (icmp_type_code == {ICMP_ECHO_REQUEST, 8'd0}) && header_checks[2]) begin
          pre.verdict    = V_ECHO;
          pre.port       = local_port;
          pre.reply_type = ICMP_ECHO_REPLY;
        end else begin
          pre.verdict = V_DROP;
        end
      end else begin
        pre.verdict    = V_PORT_UNREACH;
        pre.reply_type = ICMP_UNREACH;
        pre.reply_code = ICMP_CODE_PORT;
      end
    end else if (ttl_in <= 8'd1) begin
      pre.verdict    = V_TIME_EXCEEDED;
      pre.reply_type = ICMP_TIME_EXCEEDED;
    end else begin
      pre.need_lookup = 1'b1;
      pre.verdict     = V_NET_UNREACH;
    end
  end

endmodule

[sv/ifd_checker.sv]
// port level assertions for the ipv4 forwarding decision block, bound to the top level
module ifd_checker import ifd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              op,
  input logic              done,
  input logic [2:0]        verdict,
  input logic [ADDR_W-1:0] next_hop_ip,
  input logic [7:0]        new_ttl
);

  // a result ends the walk, so the block is free in the same cycle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // a classify transaction either answers at once or starts a walk
  a_classify_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_CLASSIFY)) |=> (done || busy))
    else $error("classify neither answered nor walking");

  // a route load gives no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_LOAD)) |=> !done)
    else $error("result after a route load");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (verdict != 3'd7))
    else $error("undefined verdict code");

  a_hop_only_forward: assert property (@(posedge clk) disable iff (rst)
    (done && (verdict != V_FORWARD)) |-> ((next_hop_ip == '0) && (new_ttl == 8'd0)))
    else $error("next hop or ttl set without forward");

endmodule

bind ipv4_forwarding_decision ifd_checker u_ifd_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .op         (op),
  .done       (done),
  .verdict    (verdict),
  .next_hop_ip(next_hop_ip),
  .new_ttl    (new_ttl)
);
